@@ design/jsu_pkg.sv @@
// Shared types, codes and helper functions for the JSON string unescape unit.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8_unit.
package jsu_pkg;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    MODE_IDLE = 4'd0,
    MODE_BODY = 4'd1,
    MODE_ESC  = 4'd2,
    MODE_H1_0 = 4'd3,
    MODE_H1_1 = 4'd4,
    MODE_H1_2 = 4'd5,
    MODE_H1_3 = 4'd6,
    MODE_BS   = 4'd7,
    MODE_U    = 4'd8,
    MODE_H2_0 = 4'd9,
    MODE_H2_1 = 4'd10,
    MODE_H2_2 = 4'd11,
    MODE_H2_3 = 4'd12
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_STRING_CHAR = 2'd1,
    ERR_UNICODE     = 2'd2,
    ERR_MISS_END    = 2'd3
  } err_t;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    kind_t           kind;
    err_t            err;
  } entry_t;

  typedef struct packed {
    logic                 valid;
    logic                 full;
    logic [QueueCntW-1:0] count;
  } queue_status_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic entry_t utf8_encode(input logic [20:0] cp);
    entry_t e;
    e = '0;
    e.kind = KIND_DATA;
    e.err  = ERR_NONE;
    if (cp <= 21'h7F) begin
      e.data[0]  = cp[7:0];
      e.last_idx = 2'd0;
    end else if (cp <= 21'h7FF) begin
      e.data[0]  = {3'b110, cp[10:6]};
      e.data[1]  = {2'b10, cp[5:0]};
      e.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      e.data[0]  = {4'b1110, cp[15:12]};
      e.data[1]  = {2'b10, cp[11:6]};
      e.data[2]  = {2'b10, cp[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.data[0]  = {5'b11110, cp[20:18]};
      e.data[1]  = {2'b10, cp[17:12]};
      e.data[2]  = {2'b10, cp[11:6]};
      e.data[3]  = {2'b10, cp[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

  function automatic entry_t single(input kind_t k, input err_t e, input logic [7:0] b);
    entry_t r;
    r = '0;
    r.data[0]  = b;
    r.last_idx = 2'd0;
    r.kind     = k;
    r.err      = e;
    return r;
  endfunction

endpackage

@@ design/jsu_front.sv @@
// Front end: escape and \u decoding state machine, one input byte per word.
// Depends on jsu_pkg; produces one result entry per byte that yields output.
module jsu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            string_start,
  output logic            push,
  output jsu_pkg::entry_t entry
);

  jsu_pkg::mode_t mode, mode_next;
  logic [15:0]    hex_accum, hex_accum_next;
  logic [9:0]     high_bits, high_bits_next;
  logic [4:0]     hv;
  logic [15:0]    hex_shift;
  logic [20:0]    cp_pair;
  logic           bad_hex;
  logic           is_high, is_low;

  assign hv        = jsu_pkg::hex_val(in_byte);
  assign bad_hex   = hv[4];
  assign hex_shift = {hex_accum[11:0], hv[3:0]};
  assign cp_pair   = 21'h10000 + {1'b0, high_bits, hex_shift[9:0]};
  assign is_high   = hex_shift >= 16'hD800 && hex_shift <= 16'hDBFF;
  assign is_low    = hex_shift >= 16'hDC00 && hex_shift <= 16'hDFFF;

  always_comb begin
    mode_next      = mode;
    hex_accum_next = hex_accum;
    high_bits_next = high_bits;
    if (string_start) begin
      mode_next      = jsu_pkg::MODE_BODY;
      hex_accum_next = '0;
      high_bits_next = '0;
    end else begin
      unique case (mode)
        jsu_pkg::MODE_BODY: begin
          if (in_byte == 8'h22 || (in_byte < 8'h20 && in_byte != 8'h5C))
            mode_next = jsu_pkg::MODE_IDLE;
          else if (in_byte == 8'h5C)
            mode_next = jsu_pkg::MODE_ESC;
        end
        jsu_pkg::MODE_ESC: begin
          unique case (in_byte)
            8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74:
              mode_next = jsu_pkg::MODE_BODY;
            8'h75: begin
              mode_next      = jsu_pkg::MODE_H1_0;
              hex_accum_next = '0;
            end
            default: mode_next = jsu_pkg::MODE_IDLE;
          endcase
        end
        jsu_pkg::MODE_H1_0, jsu_pkg::MODE_H1_1, jsu_pkg::MODE_H1_2,
        jsu_pkg::MODE_H2_0, jsu_pkg::MODE_H2_1, jsu_pkg::MODE_H2_2: begin
          if (bad_hex) begin
            mode_next = jsu_pkg::MODE_IDLE;
          end else begin
            hex_accum_next = hex_shift;
            mode_next      = jsu_pkg::mode_t'(mode + 4'd1);
          end
        end
        jsu_pkg::MODE_H1_3: begin
          if (bad_hex) begin
            mode_next = jsu_pkg::MODE_IDLE;
          end else begin
            hex_accum_next = hex_shift;
            if (is_high) begin
              high_bits_next = hex_shift[9:0];
              mode_next      = jsu_pkg::MODE_BS;
            end else begin
              mode_next = jsu_pkg::MODE_BODY;
            end
          end
        end
        jsu_pkg::MODE_H2_3: begin
          if (bad_hex) begin
            mode_next = jsu_pkg::MODE_IDLE;
          end else begin
            hex_accum_next = hex_shift;
            mode_next      = is_low ? jsu_pkg::MODE_BODY : jsu_pkg::MODE_IDLE;
          end
        end
        jsu_pkg::MODE_BS:
          mode_next = (in_byte == 8'h5C) ? jsu_pkg::MODE_U : jsu_pkg::MODE_IDLE;
        jsu_pkg::MODE_U: begin
          if (in_byte == 8'h75) begin
            mode_next      = jsu_pkg::MODE_H2_0;
            hex_accum_next = '0;
          end else begin
            mode_next = jsu_pkg::MODE_IDLE;
          end
        end
        default: mode_next = mode;
      endcase
    end
  end

  always_comb begin
    push  = 1'b0;
    entry = jsu_pkg::single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h00);
    if (!string_start) begin
      unique case (mode)
        jsu_pkg::MODE_BODY: begin
          priority if (in_byte == 8'h22) begin
            push  = 1'b1;
            entry = jsu_pkg::single(jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE, 8'h00);
          end else if (in_byte == 8'h5C) begin
            push = 1'b0;
          end else if (in_byte == 8'h00) begin
            push  = 1'b1;
            entry = jsu_pkg::single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_MISS_END, 8'h00);
          end else if (in_byte < 8'h20) begin
            push  = 1'b1;
            entry = jsu_pkg::single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_STRING_CHAR, 8'h00);
          end else begin
            push  = 1'b1;
            entry = jsu_pkg::single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, in_byte);
          end
        end
        jsu_pkg::MODE_ESC: begin
          push = 1'b1;
          unique case (in_byte)
            8'h22, 8'h5C, 8'h2F:
              entry = jsu_pkg::single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, in_byte);
            8'h62: entry = jsu_pkg::single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h08);
            8'h66: entry = jsu_pkg::single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h0C);
            8'h6E: entry = jsu_pkg::single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h0A);
            8'h72: entry = jsu_pkg::single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h0D);
            8'h74: entry = jsu_pkg::single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h09);
            8'h75: push  = 1'b0;
            default:
              entry = jsu_pkg::single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_STRING_CHAR, 8'h00);
          endcase
        end
        jsu_pkg::MODE_H1_0, jsu_pkg::MODE_H1_1, jsu_pkg::MODE_H1_2,
        jsu_pkg::MODE_H2_0, jsu_pkg::MODE_H2_1, jsu_pkg::MODE_H2_2: begin
          push  = bad_hex;
          entry = jsu_pkg::single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNICODE, 8'h00);
        end
        jsu_pkg::MODE_H1_3: begin
          if (bad_hex) begin
            push  = 1'b1;
            entry = jsu_pkg::single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNICODE, 8'h00);
          end else if (!is_high) begin
            push  = 1'b1;
            entry = jsu_pkg::utf8_encode({5'b0, hex_shift});
          end
        end
        jsu_pkg::MODE_H2_3: begin
          push = 1'b1;
          if (bad_hex || !is_low)
            entry = jsu_pkg::single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNICODE, 8'h00);
          else
            entry = jsu_pkg::utf8_encode(cp_pair);
        end
        jsu_pkg::MODE_BS: begin
          push  = in_byte != 8'h5C;
          entry = jsu_pkg::single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNICODE, 8'h00);
        end
        jsu_pkg::MODE_U: begin
          push  = in_byte != 8'h75;
          entry = jsu_pkg::single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNICODE, 8'h00);
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jsu_pkg::MODE_IDLE;
      hex_accum <= '0;
      high_bits <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_accum <= hex_accum_next;
      high_bits <= high_bits_next;
    end
  end

endmodule

@@ design/jsu_queue.sv @@
// Short queue of result entries between the decoder and the serialiser.
// Depends on jsu_pkg for the entry type and depth constants.
module jsu_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  jsu_pkg::entry_t        push_entry,
  input  logic                   pop,
  output jsu_pkg::entry_t        head,
  output jsu_pkg::queue_status_t status
);

  jsu_pkg::entry_t                 mem [jsu_pkg::QueueDepth];
  logic [jsu_pkg::QueuePtrW-1:0]   wr_ptr, rd_ptr;
  logic [jsu_pkg::QueueCntW-1:0]   count;
  logic                            do_pop;

  assign status.count = count;
  assign status.valid = count != '0;
  assign status.full  = count == jsu_pkg::QueueCntW'(jsu_pkg::QueueDepth);
  assign do_pop       = pop && status.valid;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + jsu_pkg::QueueCntW'(push) - jsu_pkg::QueueCntW'(do_pop);
    end
  end

endmodule

@@ design/jsu_back.sv @@
// Back end: serialises queued entries into one result word per cycle while out_ready is high.
// Depends on jsu_pkg; drives the master-side stream.
module jsu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  jsu_pkg::entry_t q_head,
  output logic            pop,
  output logic            busy,
  output logic [7:0]      out_byte,
  output logic [1:0]      result_kind,
  output logic [1:0]      error_code,
  output logic            run_last,
  input  logic            out_ready
);

  jsu_pkg::entry_t cur;
  logic [1:0]      idx;
  logic            load;

  assign run_last    = idx == cur.last_idx;
  assign out_byte    = cur.data[idx];
  assign result_kind = cur.kind;
  assign error_code  = cur.err;
  assign load        = !busy || (out_ready && run_last);
  assign pop         = load && q_valid;

  always_ff @(posedge clk) begin
    if (pop) cur <= q_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= q_valid;
      idx  <= '0;
    end else if (out_ready) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

@@ design/json_string_unescape_utf8_unit.sv @@
// Top level of the JSON string unescape unit: decoder, entry queue, serialiser.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Takes the body of a JSON string one byte per word, the opening quote flagged
// on s_tuser, and returns the decoded text as UTF-8 bytes, one result per word,
// followed by a close or error result; m_tlast marks the last result of each
// input byte. An input byte is taken every cycle while the four-entry result
// queue has room. Each byte yields at most one queue entry, and the serialiser
// drains one result per cycle while m_tready is high, so a \u escape that expands
// to N bytes holds the output for N result words; the queue absorbs these bursts
// and input stalls only when it fills.
module json_string_unescape_utf8_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic [0:0] s_tuser,   // [0] string_start
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [3:0] m_tuser,   // [1:0] result_kind, [3:2] error_code
  output logic       m_tlast    // run_last
);

  logic                   accept;
  logic                   push;
  logic                   pop;
  jsu_pkg::entry_t        entry;
  jsu_pkg::entry_t        head;
  jsu_pkg::queue_status_t q_status;
  logic [1:0]             kind;
  logic [1:0]             err;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (s_tdata),
    .string_start (s_tuser[0]),
    .push         (push),
    .entry        (entry)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push && accept),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_status.valid),
    .q_head      (head),
    .pop         (pop),
    .busy        (m_tvalid),
    .out_byte    (m_tdata),
    .result_kind (kind),
    .error_code  (err),
    .run_last    (m_tlast),
    .out_ready   (m_tready)
  );

  assign m_tuser = {err, kind};

  a_ctrl_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] != jsu_pkg::KIND_DATA) |-> (m_tlast && m_tdata == 8'h00))
    else $error("close or error result not a single zero word");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3:2] != jsu_pkg::ERR_NONE) |-> m_tuser[1:0] == jsu_pkg::KIND_ERROR)
    else $error("error code on a non-error result");

  a_pickup: assert property (@(posedge clk) disable iff (rst)
    (q_status.valid && !m_tvalid) |=> m_tvalid)
    else $error("queued entry not picked up by serialiser");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_status.count == jsu_pkg::QueueCntW'(jsu_pkg::QueueDepth))
    else $error("input stalled with room in queue");

endmodule

@@ tb/tb_json_string_unescape_utf8_unit.sv @@
// Testbench for json_string_unescape_utf8_unit: streams JSON string bodies in and
// checks every result word against a decoder kept alongside the stimulus.
// Depends on jsu_pkg and the RTL of the unit.
module tb_json_string_unescape_utf8_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int QuietTail  = 40;
  localparam int RandItems  = 330;
  localparam logic [7:0] Quote  = 8'h22;
  localparam logic [7:0] Bslash = 8'h5C;
  localparam logic [7:0] Slash  = 8'h2F;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
  } text_word_t;

  typedef struct packed {
    logic [7:0]     b;
    jsu_pkg::kind_t kind;
    jsu_pkg::err_t  err;
    logic           last;
  } utf8_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;
  logic       m_tlast;

  jsu_pkg::mode_t dec_mode = jsu_pkg::MODE_IDLE;
  logic [15:0]    dec_hex = '0;
  logic [9:0]     dec_hi = '0;

  text_word_t  text_q[$];
  utf8_word_t  utf8_q[$];
  int          mismatches = 0;
  int          bytes_taken = 0;
  int          cycles = 0;
  int          src_gap = 0;
  int          sink_gap = 0;
  logic        sink_hold = 1'b0;
  logic [63:0] taken_stamp = '1;

  always #1 clk = ~clk;

  json_string_unescape_utf8_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  task automatic queue_result(logic [7:0] b, jsu_pkg::kind_t k, jsu_pkg::err_t e,
                              logic last);
    utf8_word_t w;
    w = '{b, k, e, last};
    utf8_q.insert(utf8_q.size(), w);
  endtask

  task automatic fail_string(jsu_pkg::err_t e);
    dec_mode = jsu_pkg::MODE_IDLE;
    queue_result(8'h00, jsu_pkg::KIND_ERROR, e, 1'b1);
  endtask

  task automatic encode_cp(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      queue_result(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
    end else if (cp <= 21'h7FF) begin
      queue_result({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0);
      queue_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
    end else if (cp <= 21'hFFFF) begin
      queue_result({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0);
      queue_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0);
      queue_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
    end else begin
      queue_result({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0);
      queue_result({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0);
      queue_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0);
      queue_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
    end
  endtask

  task automatic decode_byte(logic [7:0] c, logic st);
    int          h;
    logic [15:0] unit;
    if (st) begin
      dec_mode = jsu_pkg::MODE_BODY;
      dec_hex  = '0;
      dec_hi   = '0;
    end else begin
      case (dec_mode)
        jsu_pkg::MODE_BODY: begin
          if (c == Quote) begin
            dec_mode = jsu_pkg::MODE_IDLE;
            queue_result(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE, 1'b1);
          end else if (c == Bslash) begin
            dec_mode = jsu_pkg::MODE_ESC;
          end else if (c == 8'h00) begin
            fail_string(jsu_pkg::ERR_MISS_END);
          end else if (c < 8'h20) begin
            fail_string(jsu_pkg::ERR_STRING_CHAR);
          end else begin
            queue_result(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
          end
        end
        jsu_pkg::MODE_ESC: begin
          dec_mode = jsu_pkg::MODE_BODY;
          case (c)
            Quote, Bslash, Slash:
              queue_result(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
            "b": queue_result(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
            "f": queue_result(8'h0C, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
            "n": queue_result(8'h0A, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
            "r": queue_result(8'h0D, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
            "t": queue_result(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b1);
            "u": begin
              dec_hex  = '0;
              dec_mode = jsu_pkg::MODE_H1_0;
            end
            default: fail_string(jsu_pkg::ERR_STRING_CHAR);
          endcase
        end
        jsu_pkg::MODE_H1_0, jsu_pkg::MODE_H1_1, jsu_pkg::MODE_H1_2, jsu_pkg::MODE_H1_3,
        jsu_pkg::MODE_H2_0, jsu_pkg::MODE_H2_1, jsu_pkg::MODE_H2_2, jsu_pkg::MODE_H2_3: begin
          h = hex_digit(c);
          if (h < 0) begin
            fail_string(jsu_pkg::ERR_UNICODE);
          end else begin
            unit    = {dec_hex[11:0], h[3:0]};
            dec_hex = unit;
            if (dec_mode == jsu_pkg::MODE_H1_3) begin
              if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                dec_hi   = unit[9:0];
                dec_mode = jsu_pkg::MODE_BS;
              end else begin
                dec_mode = jsu_pkg::MODE_BODY;
                encode_cp({5'b0, unit});
              end
            end else if (dec_mode == jsu_pkg::MODE_H2_3) begin
              if (unit < 16'hDC00 || unit > 16'hDFFF) begin
                fail_string(jsu_pkg::ERR_UNICODE);
              end else begin
                dec_mode = jsu_pkg::MODE_BODY;
                encode_cp({1'b0, dec_hi, unit[9:0]} + 21'h10000);
              end
            end else begin
              dec_mode = jsu_pkg::mode_t'(dec_mode + 4'd1);
            end
          end
        end
        jsu_pkg::MODE_BS: begin
          if (c != Bslash) fail_string(jsu_pkg::ERR_UNICODE);
          else dec_mode = jsu_pkg::MODE_U;
        end
        jsu_pkg::MODE_U: begin
          if (c != "u") begin
            fail_string(jsu_pkg::ERR_UNICODE);
          end else begin
            dec_hex  = '0;
            dec_mode = jsu_pkg::MODE_H2_0;
          end
        end
        default: ;
      endcase
    end
  endtask

  // Driver and monitor both see the handshake; whichever runs first takes the word.
  task automatic take_input();
    if (taken_stamp != $time) begin
      taken_stamp = $time;
      decode_byte(s_tdata, s_tuser[0]);
      void'(text_q.pop_front());
      bytes_taken++;
    end
  endtask

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic put_word(logic [7:0] b, logic st);
    text_word_t w;
    w = '{b, st};
    text_q.insert(text_q.size(), w);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
    return b;
  endfunction

  task automatic put_unit(logic [15:0] u);
    put_word(Bslash, 1'b0);
    put_word("u", 1'b0);
    for (int i = 3; i >= 0; i--) put_word(hex_char(u[i*4 +: 4]), 1'b0);
  endtask

  task automatic put_bad_hex();
    int k;
    k = $urandom_range(0, 3);
    put_word(Bslash, 1'b0);
    put_word("u", 1'b0);
    repeat (k) put_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
    put_word(non_hex(), 1'b0);
  endtask

  task automatic put_token();
    string       esc;
    logic [7:0]  b;
    logic [15:0] u;
    esc = "\"\\/bfnrt";
    case ($urandom_range(0, 5))
      0, 1: begin
        do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == Quote || b == Bslash);
        put_word(b, 1'b0);
      end
      2: begin
        put_word(Bslash, 1'b0);
        put_word(esc[$urandom_range(0, 7)], 1'b0);
      end
      3: begin
        case ($urandom_range(0, 3))
          0: u = 16'($urandom_range(16'h0000, 16'h007F));
          1: u = 16'($urandom_range(16'h0080, 16'h07FF));
          2: begin
            u = 16'($urandom_range(16'h0800, 16'hFFFF));
            if (u >= 16'hD800 && u <= 16'hDBFF) u = u ^ 16'h0800;
          end
          default: u = 16'($urandom_range(16'hDC00, 16'hDFFF));
        endcase
        put_unit(u);
      end
      default: begin
        put_unit(16'(16'hD800 + $urandom_range(0, 1023)));
        put_unit(16'(16'hDC00 + $urandom_range(0, 1023)));
      end
    endcase
  endtask

  task automatic put_ending();
    logic [7:0]  b;
    logic [15:0] u;
    case ($urandom_range(0, 19))
      12: put_word(8'($urandom_range(1, 31)), 1'b0);
      13: put_word(8'h00, 1'b0);
      14: begin
        put_word(Bslash, 1'b0);
        do b = 8'($urandom_range(0, 255));
        while (b inside {Quote, Bslash, Slash, "b", "f", "n", "r", "t", "u"});
        put_word(b, 1'b0);
      end
      15: begin
        if ($urandom_range(0, 1)) put_unit(16'(16'hD800 + $urandom_range(0, 1023)));
        put_bad_hex();
      end
      16: begin
        put_unit(16'(16'hD800 + $urandom_range(0, 1023)));
        case ($urandom_range(0, 2))
          0: begin
            do b = 8'($urandom_range(0, 255)); while (b == Bslash);
            put_word(b, 1'b0);
          end
          1: begin
            put_word(Bslash, 1'b0);
            do b = 8'($urandom_range(0, 255)); while (b == "u");
            put_word(b, 1'b0);
          end
          default: begin
            u = 16'($urandom_range(0, 16'hFFFF));
            if (u >= 16'hDC00 && u <= 16'hDFFF) u = u ^ 16'h2000;
            put_unit(u);
          end
        endcase
      end
      17: begin
        // abandon mid-escape; the next start word restarts the decoder
        case ($urandom_range(0, 2))
          0: put_word(Bslash, 1'b0);
          1: begin
            put_word(Bslash, 1'b0);
            put_word("u", 1'b0);
            repeat ($urandom_range(0, 3))
              put_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
          end
          default: begin
            put_unit(16'(16'hD800 + $urandom_range(0, 1023)));
            if ($urandom_range(0, 1)) put_word(Bslash, 1'b0);
          end
        endcase
      end
      default: put_word(Quote, 1'b0);
    endcase
    repeat ($urandom_range(0, 2)) put_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic put_string();
    put_word(8'($urandom_range(0, 255)), 1'b1);
    repeat ($urandom_range(0, 6)) put_token();
    put_ending();
  endtask

  // driver
  always @(posedge clk) begin
    logic       nv;
    text_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else begin
      if (s_tvalid && s_tready) take_input();
      if (!(s_tvalid && !s_tready)) begin
        nv = 1'b0;
        w  = '0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (text_q.size() == 0) begin
          nv = 1'b0;
        end else if (text_q.size() >= QuietTail && !sink_hold && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 16);
        end else begin
          nv = 1'b1;
          w  = text_q[0];
        end
        s_tvalid <= nv;
        if (nv) begin
          s_tdata <= w.b;
          s_tuser <= w.st;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    utf8_word_t want;
    logic       nr;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) take_input();
      if (m_tvalid && m_tready) begin
        if (utf8_q.size() == 0) begin
          flag_error($sformatf("unexpected word: data %h kind %0d err %0d last %b",
                               m_tdata, m_tuser[1:0], m_tuser[3:2], m_tlast));
        end else begin
          want = utf8_q.pop_front();
          if (m_tdata !== want.b || m_tuser[1:0] !== want.kind ||
              m_tuser[3:2] !== want.err || m_tlast !== want.last)
            flag_error($sformatf(
              "word mismatch: expected data %h kind %0d err %0d last %b, got %h %0d %0d %b",
              want.b, want.kind, want.err, want.last,
              m_tdata, m_tuser[1:0], m_tuser[3:2], m_tlast));
        end
      end
      nr = 1'b1;
      if (sink_hold) begin
        nr = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        nr = 1'b0;
      end else if (text_q.size() >= QuietTail && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 16);
        nr = 1'b0;
      end
      m_tready <= nr;
    end
  end

  // long hold-off on the output so the result queue fills and input stalls
  initial begin
    wait (bytes_taken >= 150);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (300) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("json_string_unescape_utf8_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int target;
    put_word(8'h41, 1'b0);
    put_word(8'hFF, 1'b1);
    put_word(8'h20, 1'b0);
    put_word(8'hFF, 1'b0);
    put_word(Bslash, 1'b0);
    put_word("t", 1'b0);
    put_unit(16'hFFFF);
    put_unit(16'hDBFF);
    put_unit(16'hDFFF);
    put_word(8'h1F, 1'b0);
    put_word(Quote, 1'b0);
    put_word(8'h00, 1'b1);
    put_word(Bslash, 1'b0);
    put_word(8'h55, 1'b1);
    put_word(8'h00, 1'b0);
    target = text_q.size() + RandItems;
    while (text_q.size() < target) put_string();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (text_q.size() == 0 && !s_tvalid && utf8_q.size() == 0);
    repeat (40) @(posedge clk);
    if (utf8_q.size() != 0)
      flag_error($sformatf("%0d result words never arrived", utf8_q.size()));
    if (mismatches == 0) begin
      $display("json_string_unescape_utf8_unit: match");
    end else begin
      $display("json_string_unescape_utf8_unit: mismatch");
    end
    $finish;
  end

endmodule
